// ===== rtl/dtq_pkg.sv =====
// Shared types and constants for the drop-tail queue timing block.
`timescale 1ns / 1ps
`default_nettype none
package dtq_pkg;

	localparam int LEN_W      = 16;  // packet length, bytes
	localparam int BT_W       = 32;  // byte time, 16.16 ns
	localparam int FRAC_W     = 16;  // fraction bits of byte time
	localparam int PROD_W     = LEN_W + BT_W;
	localparam int TX_W       = PROD_W - FRAC_W;
	localparam int CAP_W      = 7;   // buffer_capacity register
	localparam int CNT_W      = 32;  // saturating packet counters
	localparam int DELAY_W    = 64;  // delay accumulator
	localparam int OPND_W     = 64;  // adder operand width
	localparam int SUM_W      = OPND_W + 1;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CAP_W-1:0] CAP_RESET       = 7'd16;
	localparam logic [BT_W-1:0]  BYTE_TIME_RESET = 32'd47662545;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAPACITY  = 1'b0,
		REG_BYTE_TIME = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t             op;
		logic [OPND_W-1:0]   a;
		logic [OPND_W-1:0]   b;
	} alu_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DELAY,
		ST_ACCUM,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/dtq_alu.sv =====
// Shared add/subtract unit; top bit is carry on add, borrow on subtract.
`timescale 1ns / 1ps
`default_nettype none
module dtq_alu (
	input  wire dtq_pkg::alu_req_t      req,
	output logic [dtq_pkg::SUM_W-1:0]   sum
);

	always_comb begin
		unique case (req.op)
			dtq_pkg::ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
			dtq_pkg::ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
			default:          sum = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/drop_tail_queue_timing.sv =====
// Top level: drop-tail output buffer timing model with a shared adder sequencer.
//
// Input channel: in_valid/in_stall carry one packet word (arrival_time,
// packet_length). A word is taken when in_valid is high and in_stall low.
// in_stall stays high from acceptance until the result is handed to the
// output register, so the block works on one packet at a time.
// Output channel: out_valid/out_stall carry one result word per packet
// (dropped, departure_time, occupancy and the running totals).
// Steps: the single adder does a head compare, then for every departing
// packet a delay subtract, an accumulate and another compare, then a start
// compare and a departure add (skipped on a drop).
// The 16x32 length-times-byte-time product is a registered multiplier.
// A stalled receiver holds the result in the output register; the block may
// finish the next packet and then waits in its last step until it frees up.
// Reset (arst_n low) empties the queue, clears the totals and restores the
// capacity (16) and byte time registers. The packet store needs no clearing:
// only entries between head and tail are ever read. Configuration writes
// (cfg_wr_en) are meant for idle periods only.
`timescale 1ns / 1ps
`default_nettype none
module drop_tail_queue_timing #(
	parameter int BUFFER_DEPTH = 64,
	parameter int TIME_WIDTH   = 48
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// configuration
	input  wire                                   cfg_wr_en,
	input  wire  [dtq_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [dtq_pkg::CFG_DATA_W-1:0]        cfg_data,
	// input channel
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  [TIME_WIDTH-1:0]                 arrival_time,
	input  wire  [dtq_pkg::LEN_W-1:0]             packet_length,
	// output channel
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic                                  dropped,
	output logic [TIME_WIDTH-1:0]                 departure_time,
	output logic [$clog2(BUFFER_DEPTH+1)-1:0]     occupancy,
	output logic [dtq_pkg::CNT_W-1:0]             packets_seen,
	output logic [dtq_pkg::CNT_W-1:0]             packets_lost,
	output logic [dtq_pkg::DELAY_W-1:0]           delay_sum
);

	localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int OCC_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(BUFFER_DEPTH - 1);

	// control state
	dtq_pkg::state_t                state_q, state_d;
	logic [IDX_W-1:0]               head_q, tail_q, head_d;
	logic [OCC_W-1:0]               held_q;
	logic [TIME_WIDTH-1:0]          last_dep_q;
	logic [dtq_pkg::CNT_W-1:0]      seen_q, lost_q;
	logic [dtq_pkg::DELAY_W-1:0]    delay_total_q;
	logic [dtq_pkg::CAP_W-1:0]      cap_q;
	logic [dtq_pkg::BT_W-1:0]       byte_time_q;
	logic                           out_valid_q;

	// working registers
	logic [TIME_WIDTH-1:0]          arr_q;
	logic [dtq_pkg::LEN_W-1:0]      len_q;
	logic [2*TIME_WIDTH-1:0]        rd_entry_q;
	logic [dtq_pkg::PROD_W-1:0]     prod_q;
	logic [TIME_WIDTH-1:0]          start_q;
	logic [TIME_WIDTH-1:0]          delay_q;
	logic                           drop_q;
	logic [TIME_WIDTH-1:0]          res_dep_q;

	// output word
	logic                           out_drop_q;
	logic [TIME_WIDTH-1:0]          out_dep_q;
	logic [OCC_W-1:0]               out_occ_q;
	logic [dtq_pkg::CNT_W-1:0]      out_seen_q, out_lost_q;
	logic [dtq_pkg::DELAY_W-1:0]    out_delay_q;

	// packet store: {departure, arrival} per slot
	logic [2*TIME_WIDTH-1:0]        store_mem [BUFFER_DEPTH];

	dtq_pkg::alu_req_t              alu_req;
	logic [dtq_pkg::SUM_W-1:0]      alu_sum;
	logic                           alu_borrow;
	logic                           time_ovf;
	logic [TIME_WIDTH-1:0]          dep_new;
	logic [dtq_pkg::DELAY_W-1:0]    delay_next;
	logic [TIME_WIDTH-1:0]          rd_arr, rd_dep;
	logic [dtq_pkg::TX_W-1:0]       tx;
	logic [31:0]                    cap_lim;
	logic                           full;
	logic                           accept, pop, admit, load_out;
	logic                           out_free;

	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		next_slot = (i == LAST_SLOT) ? '0 : i + IDX_W'(1);
	endfunction

	assign rd_arr = rd_entry_q[TIME_WIDTH-1:0];
	assign rd_dep = rd_entry_q[2*TIME_WIDTH-1:TIME_WIDTH];
	assign tx     = prod_q[dtq_pkg::PROD_W-1:dtq_pkg::FRAC_W];

	// capacity above the store depth acts as the depth
	assign cap_lim = (32'(cap_q) > 32'(BUFFER_DEPTH)) ? 32'(BUFFER_DEPTH) : 32'(cap_q);
	assign full    = !(32'(held_q) < cap_lim);

	assign out_free = !out_valid_q || !out_stall;

	dtq_alu u_alu (
		.req (alu_req),
		.sum (alu_sum)
	);

	assign alu_borrow = alu_sum[dtq_pkg::SUM_W-1];
	assign time_ovf   = |(alu_sum >> TIME_WIDTH);
	assign dep_new    = time_ovf ? '1 : alu_sum[TIME_WIDTH-1:0];
	assign delay_next = alu_borrow ? '1 : alu_sum[dtq_pkg::DELAY_W-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		alu_req  = '{op: dtq_pkg::ALU_ADD, a: '0, b: '0};
		accept   = 1'b0;
		pop      = 1'b0;
		admit    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			dtq_pkg::ST_IDLE: begin
				accept = in_valid;
				if (in_valid) state_d = dtq_pkg::ST_CHECK;
			end
			dtq_pkg::ST_CHECK: begin
				// head leaves if its departure is at or before the arrival
				alu_req = '{op: dtq_pkg::ALU_SUB,
					a: dtq_pkg::OPND_W'(arr_q), b: dtq_pkg::OPND_W'(rd_dep)};
				if (held_q != '0 && !alu_borrow) state_d = dtq_pkg::ST_DELAY;
				else state_d = dtq_pkg::ST_MUL;
			end
			dtq_pkg::ST_DELAY: begin
				alu_req = '{op: dtq_pkg::ALU_SUB,
					a: dtq_pkg::OPND_W'(rd_dep), b: dtq_pkg::OPND_W'(rd_arr)};
				state_d = dtq_pkg::ST_ACCUM;
			end
			dtq_pkg::ST_ACCUM: begin
				alu_req = '{op: dtq_pkg::ALU_ADD,
					a: delay_total_q, b: dtq_pkg::OPND_W'(delay_q)};
				pop     = 1'b1;
				state_d = dtq_pkg::ST_CHECK;
			end
			dtq_pkg::ST_MUL: begin
				// start = max(last departure, arrival)
				alu_req = '{op: dtq_pkg::ALU_SUB,
					a: dtq_pkg::OPND_W'(arr_q), b: dtq_pkg::OPND_W'(last_dep_q)};
				state_d = full ? dtq_pkg::ST_DONE : dtq_pkg::ST_ADD;
			end
			dtq_pkg::ST_ADD: begin
				alu_req = '{op: dtq_pkg::ALU_ADD,
					a: dtq_pkg::OPND_W'(start_q), b: dtq_pkg::OPND_W'(tx)};
				admit   = 1'b1;
				state_d = dtq_pkg::ST_DONE;
			end
			dtq_pkg::ST_DONE: begin
				load_out = out_free;
				if (out_free) state_d = dtq_pkg::ST_IDLE;
			end
			default: state_d = dtq_pkg::ST_IDLE;
		endcase
	end

	assign head_d = pop ? next_slot(head_q) : head_q;

	// queue pointers, totals and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			tail_q        <= '0;
			held_q        <= '0;
			last_dep_q    <= '0;
			seen_q        <= '0;
			lost_q        <= '0;
			delay_total_q <= '0;
			cap_q         <= dtq_pkg::CAP_RESET;
			byte_time_q   <= dtq_pkg::BYTE_TIME_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					dtq_pkg::REG_CAPACITY:  cap_q <= cfg_data[dtq_pkg::CAP_W-1:0];
					dtq_pkg::REG_BYTE_TIME: byte_time_q <= cfg_data[dtq_pkg::BT_W-1:0];
					default: ;
				endcase
			end
			head_q <= head_d;
			if (pop) begin
				held_q        <= held_q - OCC_W'(1);
				delay_total_q <= delay_next;
			end
			if (state_q == dtq_pkg::ST_MUL) begin
				if (seen_q != '1) seen_q <= seen_q + dtq_pkg::CNT_W'(1);
				if (full && lost_q != '1) lost_q <= lost_q + dtq_pkg::CNT_W'(1);
			end
			if (admit) begin
				tail_q     <= next_slot(tail_q);
				held_q     <= held_q + OCC_W'(1);
				last_dep_q <= dep_new;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			arr_q <= arrival_time;
			len_q <= packet_length;
		end
		if (state_q == dtq_pkg::ST_DELAY) delay_q <= alu_sum[TIME_WIDTH-1:0];
		if (state_q == dtq_pkg::ST_MUL) begin
			prod_q    <= dtq_pkg::PROD_W'(len_q) * dtq_pkg::PROD_W'(byte_time_q);
			start_q   <= alu_borrow ? last_dep_q : arr_q;
			drop_q    <= full;
			res_dep_q <= '0;
		end
		if (admit) res_dep_q <= dep_new;
		if (load_out) begin
			out_drop_q  <= drop_q;
			out_dep_q   <= res_dep_q;
			out_occ_q   <= held_q;
			out_seen_q  <= seen_q;
			out_lost_q  <= lost_q;
			out_delay_q <= delay_total_q;
		end
	end

	// packet store; read port follows the next head
	always_ff @(posedge clk) begin
		if (admit) store_mem[tail_q] <= {dep_new, arr_q};
		rd_entry_q <= store_mem[head_d];
	end

	assign in_stall       = (state_q != dtq_pkg::ST_IDLE);
	assign out_valid      = out_valid_q;
	assign dropped        = out_drop_q;
	assign departure_time = out_dep_q;
	assign occupancy      = out_occ_q;
	assign packets_seen   = out_seen_q;
	assign packets_lost   = out_lost_q;
	assign delay_sum      = out_delay_q;

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(held_q) <= 32'(BUFFER_DEPTH))
		else $error("occupancy above store depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != '0 && held_q != OCC_W'(BUFFER_DEPTH)) |-> (head_q != tail_q))
		else $error("head and tail disagree with occupancy");

	a_held_step: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != $past(held_q)) |->
			(held_q == $past(held_q) + OCC_W'(1) || held_q + OCC_W'(1) == $past(held_q)))
		else $error("occupancy moved by more than one");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dtq_pkg::ST_ACCUM) |-> (held_q != '0))
		else $error("pop from empty buffer");

	a_drop_zero_dep: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_drop_q) |-> (out_dep_q == '0))
		else $error("dropped packet carries a departure time");
`endif

endmodule
`default_nettype wire

// ===== tb/drop_tail_queue_timing_tb.sv =====
// Self-checking testbench for drop_tail_queue_timing: packet stimulus, buffer predictor, checker.
`timescale 1ns / 1ps
module drop_tail_queue_timing_tb;

	localparam int TW     = 48;
	localparam int DEPTH  = 64;
	localparam int OCC_W  = $clog2(DEPTH + 1);
	localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

	localparam int LONG_HOLD      = 400;
	localparam int SETTLE_CYCLES  = 20;
	localparam int END_PAUSE      = 250;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 200;

	typedef struct packed {
		logic [TW-1:0]             arrival;
		logic [dtq_pkg::LEN_W-1:0] length;
	} packet_t;

	typedef struct packed {
		logic                        dropped;
		logic [TW-1:0]               departure;
		logic [OCC_W-1:0]            occupancy;
		logic [dtq_pkg::CNT_W-1:0]   seen;
		logic [dtq_pkg::CNT_W-1:0]   lost;
		logic [dtq_pkg::DELAY_W-1:0] delay;
	} result_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [dtq_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dtq_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic [TW-1:0]                  arrival_time;
	logic [dtq_pkg::LEN_W-1:0]      packet_length;
	logic                           out_valid;
	logic                           out_stall;
	logic                           dropped;
	logic [TW-1:0]                  departure_time;
	logic [OCC_W-1:0]               occupancy;
	logic [dtq_pkg::CNT_W-1:0]      packets_seen;
	logic [dtq_pkg::CNT_W-1:0]      packets_lost;
	logic [dtq_pkg::DELAY_W-1:0]    delay_sum;

	drop_tail_queue_timing #(
		.BUFFER_DEPTH(DEPTH),
		.TIME_WIDTH(TW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.arrival_time(arrival_time),
		.packet_length(packet_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dropped(dropped),
		.departure_time(departure_time),
		.occupancy(occupancy),
		.packets_seen(packets_seen),
		.packets_lost(packets_lost),
		.delay_sum(delay_sum)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Buffer predictor: own copy of the queue, totals and registers.
	// ------------------------------------------------------------------
	logic [TW-1:0]               arr_store [DEPTH];
	logic [TW-1:0]               dep_store [DEPTH];
	int                          head = 0;
	int                          tail = 0;
	int                          held = 0;
	logic [TW-1:0]               last_dep = '0;
	logic [dtq_pkg::CNT_W-1:0]   seen_cnt = '0;
	logic [dtq_pkg::CNT_W-1:0]   lost_cnt = '0;
	logic [dtq_pkg::DELAY_W-1:0] delay_acc = '0;
	logic [dtq_pkg::CAP_W-1:0]   cap_reg = dtq_pkg::CAP_RESET;
	logic [dtq_pkg::BT_W-1:0]    bt_reg = dtq_pkg::BYTE_TIME_RESET;

	packet_t packets_to_send [$];   // words the driver still has to offer
	result_t awaited_results [$];   // predicted result words, oldest first

	// run statistics for the summary
	int mismatches = 0;
	int results_checked = 0;
	int drop_count = 0;
	int saturated_count = 0;
	int deepest = 0;
	int most_pops = 0;
	int regs_written = 0;

	// stimulus controls, changed only at the falling edge
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	logic [63:0] arrival_clock = '0;

	// Transmission time: length times 16.16 byte time, fraction dropped.
	function automatic logic [TW-1:0] tx_ns(input logic [dtq_pkg::LEN_W-1:0] len,
			input logic [dtq_pkg::BT_W-1:0] bt);
		logic [dtq_pkg::PROD_W-1:0] prod;
		prod = len * bt;
		return TW'(prod >> dtq_pkg::FRAC_W);
	endfunction

	// One arrival: drain departed packets, then admit or drop at the tail.
	task automatic serve_arrival(input logic [TW-1:0] arr,
			input logic [dtq_pkg::LEN_W-1:0] len);
		int lim;
		int pops;
		logic [TW-1:0] wait_ns;
		logic [dtq_pkg::DELAY_W:0] acc;
		logic [TW-1:0] start_ns;
		logic [TW:0] dep_sum;
		result_t r;
		lim = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
		pops = 0;
		while (held > 0 && dep_store[head] <= arr) begin
			wait_ns = dep_store[head] - arr_store[head];
			acc = {1'b0, delay_acc} + wait_ns;
			delay_acc = acc[dtq_pkg::DELAY_W] ? '1 : acc[dtq_pkg::DELAY_W-1:0];
			head = (head + 1) % DEPTH;
			held--;
			pops++;
		end
		if (seen_cnt != '1)
			seen_cnt++;
		r = '0;
		if (held < lim) begin
			start_ns = (last_dep > arr) ? last_dep : arr;
			dep_sum = {1'b0, start_ns} + tx_ns(len, bt_reg);
			r.departure = dep_sum[TW] ? TIME_MAX : dep_sum[TW-1:0];
			if (dep_sum[TW])
				saturated_count++;
			last_dep = r.departure;
			arr_store[tail] = arr;
			dep_store[tail] = r.departure;
			tail = (tail + 1) % DEPTH;
			held++;
		end else begin
			r.dropped = 1'b1;
			if (lost_cnt != '1)
				lost_cnt++;
			drop_count++;
		end
		r.occupancy = OCC_W'(held);
		r.seen = seen_cnt;
		r.lost = lost_cnt;
		r.delay = delay_acc;
		if (held > deepest)
			deepest = held;
		if (pops > most_pops)
			most_pops = pops;
		awaited_results.insert(awaited_results.size(), r);
	endtask

	// ------------------------------------------------------------------
	// Driver: offers queued packet words; a stalled word holds steady.
	// Prediction happens at the accepting edge from the driven payload.
	// ------------------------------------------------------------------
	packet_t nxt_pkt;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				serve_arrival(arrival_time, packet_length);
			if (!in_valid || !in_stall) begin
				if (packets_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt_pkt = packets_to_send.pop_front();
					in_valid <= 1'b1;
					arrival_time <= nxt_pkt.arrival;
					packet_length <= nxt_pkt.length;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver stall: random per cycle, or a long hold on request so the
	// output register fills and the block backs up into in_stall.
	// ------------------------------------------------------------------
	int hold_left = 0;
	int hold_served = 0;

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_left <= LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: each accepted result word against the oldest prediction.
	// ------------------------------------------------------------------
	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %0h, actual %0h",
					$time, field, want, got);
		end
	endtask

	result_t want_r;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"%0t ns: result word with none expected, ",
						"expected nothing, actual departure %0h"},
						$time, departure_time);
			end else begin
				want_r = awaited_results.pop_front();
				check_field("dropped", want_r.dropped, dropped);
				check_field("departure_time", want_r.departure, departure_time);
				check_field("occupancy", want_r.occupancy, occupancy);
				check_field("packets_seen", want_r.seen, packets_seen);
				check_field("packets_lost", want_r.lost, packets_lost);
				check_field("delay_sum", want_r.delay, delay_sum);
				results_checked++;
			end
		end
	end

	// Watchdog: too long with no word moving on either channel.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequencing helpers
	// ------------------------------------------------------------------
	// Register write while idle; the predictor copy follows at once.
	task automatic write_reg(input dtq_pkg::cfg_reg_t idx,
			input logic [dtq_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			dtq_pkg::REG_CAPACITY: begin
				cap_reg = val[dtq_pkg::CAP_W-1:0];
			end
			dtq_pkg::REG_BYTE_TIME: begin
				bt_reg = val[dtq_pkg::BT_W-1:0];
			end
		endcase
		regs_written++;
		@(negedge clk);
	endtask

	task automatic queue_packet(input logic [TW-1:0] arr,
			input logic [dtq_pkg::LEN_W-1:0] len);
		packet_t p;
		p.arrival = arr;
		p.length = len;
		packets_to_send.insert(packets_to_send.size(), p);
	endtask

	// Sender pause: nothing offered until every predicted word is back.
	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (packets_to_send.size() != 0 || in_valid || awaited_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly steady arrivals spaced against the transmission time, so the
	// buffer fills and drains; the rest are repeats, backward steps, odd
	// lengths and long gaps that empty the whole buffer in one arrival.
	task automatic queue_traffic(input int n, input int scale_pct, input int len_hi);
		int r;
		logic [dtq_pkg::LEN_W-1:0] len;
		logic [63:0] gap;
		logic [63:0] back;
		logic [TW-1:0] arr;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			len = (r < 5) ? dtq_pkg::LEN_W'($urandom)
				: dtq_pkg::LEN_W'($urandom_range(0, len_hi));
			gap = 64'(tx_ns(dtq_pkg::LEN_W'($urandom_range(0, len_hi)), bt_reg))
				* scale_pct / 100 + $urandom_range(0, 3);
			if (r >= 97)
				gap = 64'(tx_ns({dtq_pkg::LEN_W{1'b1}}, bt_reg)) * DEPTH + 1;
			if (r >= 88 && r < 93) begin
				back = 64'(tx_ns(len, bt_reg)) + $urandom_range(0, 100);
				arr = (arrival_clock > back) ? TW'(arrival_clock - back) : '0;
			end else if (r >= 93 && r < 97) begin
				arr = TW'(arrival_clock);
			end else begin
				arrival_clock += gap;
				arr = TW'(arrival_clock);
			end
			queue_packet(arr, len);
		end
	endtask

	// One random phase: registers, idling mode, then traffic in two halves
	// with a full drain between them.
	task automatic run_load_phase(input logic [dtq_pkg::CAP_W-1:0] cap,
			input logic [dtq_pkg::BT_W-1:0] bt,
			input int n, input int scale_pct, input int len_hi,
			input int idle_in, input int stall_in, input bit long_hold);
		write_reg(dtq_pkg::REG_CAPACITY, dtq_pkg::CFG_DATA_W'(cap));
		write_reg(dtq_pkg::REG_BYTE_TIME, bt);
		send_idle_pct = idle_in;
		stall_pct = stall_in;
		if (long_hold)
			hold_requests++;
		queue_traffic(n / 2, scale_pct, len_hi);
		wait_until_drained();
		queue_traffic(n - n / 2, scale_pct, len_hi);
		wait_until_drained();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = dtq_pkg::REG_CAPACITY;
		cfg_data = '0;
		in_valid = 1'b0;
		arrival_time = '0;
		packet_length = '0;
		out_stall = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers: zero-length packets at time zero (second one pops
		// the first at equal time), a maximum length, a backward arrival
		queue_packet('0, '0);
		queue_packet('0, '0);
		queue_packet('0, {dtq_pkg::LEN_W{1'b1}});
		queue_packet(TW'(100), dtq_pkg::LEN_W'(1));
		queue_packet(TW'(50), dtq_pkg::LEN_W'(40));
		wait_until_drained();
		// arrival exactly at the last departure empties the buffer
		queue_packet(last_dep, dtq_pkg::LEN_W'(1500));
		wait_until_drained();

		// capacity zero drops everything, largest byte time
		write_reg(dtq_pkg::REG_CAPACITY, '0);
		write_reg(dtq_pkg::REG_BYTE_TIME, {dtq_pkg::BT_W{1'b1}});
		arrival_clock = 64'(last_dep) + 10;
		repeat (3) queue_packet(TW'(arrival_clock), {dtq_pkg::LEN_W{1'b1}});
		wait_until_drained();

		// capacity above depth, zero byte time: departure equals arrival,
		// and each later word at the same time pops the one before it
		write_reg(dtq_pkg::REG_CAPACITY, dtq_pkg::CFG_DATA_W'(127));
		write_reg(dtq_pkg::REG_BYTE_TIME, '0);
		repeat (5) queue_packet(TW'(arrival_clock),
			dtq_pkg::LEN_W'($urandom_range(0, 65535)));
		wait_until_drained();

		// capacity two: fill, overflow, then drain
		write_reg(dtq_pkg::REG_CAPACITY, dtq_pkg::CFG_DATA_W'(2));
		write_reg(dtq_pkg::REG_BYTE_TIME, dtq_pkg::CFG_DATA_W'(32'h0001_0000));
		arrival_clock += 100;
		repeat (4) queue_packet(TW'(arrival_clock), dtq_pkg::LEN_W'(1000));
		queue_packet(TW'(arrival_clock + 5000), dtq_pkg::LEN_W'(1000));
		wait_until_drained();
		arrival_clock = 64'(last_dep) + 1;

		// random phases across capacity, byte time and idling mode
		run_load_phase(7'd16, dtq_pkg::BYTE_TIME_RESET, 250, 80, 1500, 0, 0, 1'b0);
		run_load_phase(7'd64, dtq_pkg::BYTE_TIME_RESET, 250, 70, 1500, 84, 0, 1'b0);
		run_load_phase(7'd1, 32'h0001_0000, 200, 100, 1500, 0, 84, 1'b0);
		run_load_phase(7'd127, 32'hFFFF_FFFF, 250, 60, 65535, 10, 10, 1'b0);
		run_load_phase(7'd0, 32'd1, 60, 100, 1500, 0, 0, 1'b0);
		run_load_phase(7'd8, 32'd0, 150, 100, 1500, 84, 0, 1'b0);
		run_load_phase(7'd64, 32'h0003_0000, 250, 50, 1500, 10, 10, 1'b1);
		run_load_phase(7'd32, dtq_pkg::BYTE_TIME_RESET, 250, 95, 1500, 0, 84, 1'b0);

		// time overflow last: once the last departure sticks at the top of
		// the time range it never comes back down
		send_idle_pct = 0;
		stall_pct = 0;
		write_reg(dtq_pkg::REG_CAPACITY, dtq_pkg::CFG_DATA_W'(64));
		write_reg(dtq_pkg::REG_BYTE_TIME, {dtq_pkg::BT_W{1'b1}});
		queue_packet(TIME_MAX - 5, {dtq_pkg::LEN_W{1'b1}});
		queue_packet(TIME_MAX - 5, '0);
		queue_packet(TIME_MAX, dtq_pkg::LEN_W'(1));
		queue_packet('0, dtq_pkg::LEN_W'(7));
		wait_until_drained();

		repeat (END_PAUSE) @(negedge clk);
		$display("Checked %0d result words under %0d register writes: %0d dropped, %0d %s",
			results_checked, regs_written, drop_count, saturated_count,
			"saturated departures.");
		$display("Deepest buffer %0d packets; most departures on one arrival %0d.",
			deepest, most_pops);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
